[hdl/smf_pkg.sv]
// ---------------------------------------------------------------------------
// smf_pkg: shared types and constants of the separable 3x3 mean filter
// Request payloads, step control flags, register indexes and the rounded
// divide-by-three used by both filter passes.
// ---------------------------------------------------------------------------
package smf_pkg;

	// Request kinds on the input channel
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_DRAIN  = 1'b1;

	// Configuration register indexes
	localparam int unsigned REG_IDX_W    = 2;
	localparam logic [REG_IDX_W-1:0] REG_WIDTH    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CHANNELS = 2'd2;
	localparam int unsigned CFG_DATA_W   = 12;

	// Output queue geometry
	localparam int unsigned OUT_DEPTH = 4;
	localparam int unsigned OUT_PW    = 2;
	localparam int unsigned OUT_CW    = 3;

	typedef struct packed {
		logic       op;
		logic [7:0] sample;
	} in_t;

	typedef struct packed {
		logic [7:0] filtered;
		logic       frame_last;
	} out_t;

	// Control flags of one filter step handed from the front end to the
	// vertical stage
	typedef struct packed {
		logic wr;     // update both row stores
		logic emit;   // step yields a result
		logic drain;  // bottom edge: current row replaced by middle row
		logic upmid;  // top edge: upper row replaced by middle row
		logic last;   // final result of the frame
	} step_ctl_t;

	// (sum + 1) / 3 by reciprocal multiply, exact for sums up to 765
	function automatic logic [7:0] mean3(input logic [9:0] sum);
		logic [10:0] n;
		logic [21:0] p;
		n = {1'b0, sum} + 11'd1;
		p = 22'(n) * 22'd683;
		return p[18:11];
	endfunction

endpackage

[hdl/separable_mean_filter_3x3.sv]
// ---------------------------------------------------------------------------
// separable_mean_filter_3x3: 3x3 box filter on interleaved 8-bit samples
// Horizontal then vertical 3-tap mean with edge replication, on a raster
// stream, using two row stores in synchronous memory.
// ---------------------------------------------------------------------------
// Usage:
//   item (valid/ready) carries sample requests (op = sample) in raster order,
//   channels interleaved, and drain requests (op = drain) after the frame's
//   last sample; each drain request returns one pending result. Samples past
//   the end of the frame and drains before it are taken and dropped.
//   result (valid/ready) carries filtered values in raster order; the final
//   one of a frame has frame_last set, after which a new frame may start.
//   cfg_wen/cfg_index/cfg_data write width, height and channel count while
//   the block is idle; a write to any of these registers restarts the frame.
// Timing:
//   One request per cycle while item_ready is high. A result is due
//   width*channels+channels steps after its sample; from the step that
//   produces it, it passes through the row store read and merge stage
//   register and the result queue to the result port.
// Reset and stalls:
//   Reset restores 640x480, one channel, and an empty frame; the row stores
//   are not cleared. A stalled result port fills the result queue; item_ready
//   drops once three results are queued or in flight, until space returns.
// ---------------------------------------------------------------------------
module separable_mean_filter_3x3 #(
	parameter int unsigned MAX_WIDTH    = 2048,
	parameter int unsigned MAX_CHANNELS = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  smf_pkg::in_t                        item,
	output logic                                result_valid,
	input  logic                                result_ready,
	output smf_pkg::out_t                       result,
	input  logic                                cfg_wen,
	input  logic [smf_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [smf_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import smf_pkg::*;

	localparam int unsigned DEPTH = MAX_WIDTH * MAX_CHANNELS;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	logic [11:0] width_q, height_q;
	logic [2:0]  chan_q;
	logic        restart;

	logic [13:0]   w_eff, w_m1;
	logic [2:0]    ch_eff, ch_m1;
	logic [XW-1:0] wm1;
	logic [CW-1:0] chm1;
	logic [11:0]   hm1;

	logic          room, step_valid, push, pend;
	step_ctl_t     ctl;
	logic [AW-1:0] addr;
	logic [7:0]    hn;
	out_t          res;

	// Configuration registers; a write to a known index restarts the frame
	assign restart = cfg_wen && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT) ||
		(cfg_index == REG_CHANNELS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 12'd640;
			height_q <= 12'd480;
			chan_q   <= 3'd1;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_WIDTH:    width_q  <= cfg_data;
				REG_HEIGHT:   height_q <= cfg_data;
				REG_CHANNELS: chan_q   <= cfg_data[2:0];
				default:      ;
			endcase
		end
	end

	// Clamp the geometry to the supported range
	always_comb begin
		priority if (width_q == 12'd0) begin
			w_eff = 14'd1;
		end else if ({2'b00, width_q} > 14'(MAX_WIDTH)) begin
			w_eff = 14'(MAX_WIDTH);
		end else begin
			w_eff = {2'b00, width_q};
		end
		priority if (chan_q == 3'd0) begin
			ch_eff = 3'd1;
		end else if (chan_q > 3'(MAX_CHANNELS)) begin
			ch_eff = 3'(MAX_CHANNELS);
		end else begin
			ch_eff = chan_q;
		end
	end

	assign w_m1  = w_eff - 14'd1;
	assign ch_m1 = ch_eff - 3'd1;
	assign wm1   = w_m1[XW-1:0];
	assign chm1  = ch_m1[CW-1:0];
	assign hm1   = (height_q == 12'd0) ? 12'd0 : (height_q - 12'd1);

	// Request sequencing and horizontal pass
	smf_front #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.XW           (XW),
		.CW           (CW),
		.AW           (AW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (restart),
		.wm1        (wm1),
		.chm1       (chm1),
		.hm1        (hm1),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.room       (room),
		.step_valid (step_valid),
		.ctl        (ctl),
		.addr       (addr),
		.hn         (hn)
	);

	// Vertical pass over the row stores
	smf_vert #(.DEPTH(DEPTH), .AW(AW)) u_vert (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_valid (step_valid),
		.ctl        (ctl),
		.addr       (addr),
		.hn         (hn),
		.push       (push),
		.res        (res),
		.pend       (pend)
	);

	// Result queue towards the receiver
	smf_out_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.din     (res),
		.reserve (pend),
		.room    (room),
		.valid   (result_valid),
		.ready   (result_ready),
		.dout    (result)
	);

	// A step that yields a result is only issued with queue space reserved
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		step_valid && ctl.emit |-> room)
		else $error("emitting step issued without queue space");

	// Every queued result comes from an emitting step in the previous cycle
	a_push_origin: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> $past(step_valid && ctl.emit))
		else $error("result pushed without a matching step");

	// The frame's final step returns the sequencer to the frame start
	a_last_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step_valid && ctl.last |=> !step_valid)
		else $error("filter step issued straight after frame end");

endmodule

[hdl/smf_row_ram.sv]
// ---------------------------------------------------------------------------
// smf_row_ram: one-write one-read row store
// Synchronous memory of 8-bit entries; read data is registered and returns
// the old contents when read and write hit the same address in one cycle.
// ---------------------------------------------------------------------------
module smf_row_ram #(
	parameter int unsigned DEPTH = 8192,
	parameter int unsigned AW    = 13
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/smf_out_fifo.sv]
// ---------------------------------------------------------------------------
// smf_out_fifo: result queue
// Small register queue between the filter pipeline and the result channel;
// reports room for one more step while counting the result still in flight.
// ---------------------------------------------------------------------------
module smf_out_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  smf_pkg::out_t din,
	input  logic          reserve,
	output logic          room,
	output logic          valid,
	input  logic          ready,
	output smf_pkg::out_t dout
);
	import smf_pkg::*;

	out_t              mem_q [OUT_DEPTH];
	logic [OUT_PW-1:0] wp_q, rp_q;
	logic [OUT_CW-1:0] count_q;
	logic              pop;

	// Status towards both sides
	assign valid = (count_q != '0);
	assign dout  = mem_q[rp_q];
	assign pop   = valid && ready;
	assign room  = (count_q + OUT_CW'(reserve)) < OUT_CW'(OUT_DEPTH - 1);

	// Hold queued results
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= din;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hdl/smf_front.sv]
// ---------------------------------------------------------------------------
// smf_front: request sequencer and horizontal pass
// Sorts requests into filter steps, keeps the raster position of the sample
// being finished, holds the sample window and forms the horizontal mean.
// ---------------------------------------------------------------------------
module smf_front #(
	parameter int unsigned MAX_CHANNELS = 4,
	parameter int unsigned XW = 11,
	parameter int unsigned CW = 2,
	parameter int unsigned AW = 13
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               restart,
	input  logic [XW-1:0]      wm1,
	input  logic [CW-1:0]      chm1,
	input  logic [11:0]        hm1,
	input  logic               item_valid,
	output logic               item_ready,
	input  smf_pkg::in_t       item,
	input  logic               room,
	output logic               step_valid,
	output smf_pkg::step_ctl_t ctl,
	output logic [AW-1:0]      addr,
	output logic [7:0]         hn
);
	import smf_pkg::*;

	localparam int unsigned WD  = 2 * MAX_CHANNELS;
	localparam int unsigned WIW = $clog2(WD);

	logic          warm_q;
	logic [CW-1:0] wc_q;
	logic [CW-1:0] c_q;
	logic [XW-1:0] x_q;
	logic [AW-1:0] j_q;
	logic [11:0]   row_q;
	logic          burst_q;
	logic [7:0]    win_q [WD];

	logic       row_end, horiz, complete, emit_now;
	logic       acc, take_smp, take_drn, go, frame_done;
	logic [7:0] v, cur, prev;
	logic [9:0] hsum;

	// Classify the pending position and the request
	assign row_end    = (x_q == wm1) && (c_q == chm1);
	assign horiz      = (row_q <= hm1);
	assign complete   = warm_q && (((row_q == hm1) && (x_q == wm1)) || !horiz);
	assign emit_now   = warm_q && (row_q != 12'd0);
	assign item_ready = !burst_q && room;
	assign acc        = item_valid && item_ready;
	assign take_smp   = acc && (item.op == OP_SAMPLE) && !complete;
	assign take_drn   = acc && (item.op == OP_DRAIN) && complete;
	assign go         = take_smp || take_drn || (burst_q && room);
	assign v          = take_smp ? item.sample : 8'd0;

	// Horizontal mean with the edge sample replicated
	assign cur  = win_q[WIW'(chm1)];
	assign prev = win_q[WIW'({chm1, 1'b1})];

	always_comb begin
		priority if (x_q == '0) begin
			hsum = {2'b00, cur} + {2'b00, cur} + {2'b00, v};
		end else if (x_q == wm1) begin
			hsum = {2'b00, prev} + {2'b00, cur} + {2'b00, cur};
		end else begin
			hsum = {2'b00, prev} + {2'b00, cur} + {2'b00, v};
		end
	end

	assign hn = (wm1 == '0) ? cur : mean3(hsum);

	// Step handed to the vertical stage
	assign step_valid = go && warm_q;
	assign addr       = j_q;
	assign ctl.wr     = horiz;
	assign ctl.emit   = (row_q != 12'd0);
	assign ctl.drain  = !horiz;
	assign ctl.upmid  = horiz ? (row_q == 12'd1) : (hm1 == 12'd0);
	assign ctl.last   = !horiz && row_end;
	assign frame_done = step_valid && ctl.last;

	// Advance the raster position; drop back to the frame start when done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q  <= 1'b0;
			wc_q    <= '0;
			c_q     <= '0;
			x_q     <= '0;
			j_q     <= '0;
			row_q   <= '0;
			burst_q <= 1'b0;
		end else if (restart || frame_done) begin
			warm_q  <= 1'b0;
			wc_q    <= '0;
			c_q     <= '0;
			x_q     <= '0;
			j_q     <= '0;
			row_q   <= '0;
			burst_q <= 1'b0;
		end else if (go) begin
			if (!warm_q) begin
				if (wc_q == chm1) begin
					warm_q <= 1'b1;
					wc_q   <= '0;
				end else begin
					wc_q <= wc_q + 1'b1;
				end
			end else if (c_q != chm1) begin
				c_q <= c_q + 1'b1;
				j_q <= j_q + 1'b1;
			end else if (x_q != wm1) begin
				c_q <= '0;
				x_q <= x_q + 1'b1;
				j_q <= j_q + 1'b1;
			end else begin
				c_q   <= '0;
				x_q   <= '0;
				j_q   <= '0;
				row_q <= row_q + 1'b1;
			end
			// a drain request keeps stepping until one step yields a result
			if (emit_now) begin
				burst_q <= 1'b0;
			end else if (take_drn) begin
				burst_q <= 1'b1;
			end
		end
	end

	// Shift the sample window on every step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WD; k++) begin
				win_q[k] <= 8'd0;
			end
		end else if (restart || frame_done) begin
			for (int k = 0; k < WD; k++) begin
				win_q[k] <= 8'd0;
			end
		end else if (go) begin
			win_q[0] <= v;
			for (int k = 1; k < WD; k++) begin
				win_q[k] <= win_q[k-1];
			end
		end
	end

endmodule

[hdl/smf_vert.sv]
// ---------------------------------------------------------------------------
// smf_vert: vertical pass over the row stores
// Reads the two stored rows at the step's column, forwards the entry written
// in the previous cycle, forms the vertical mean and writes the rows back.
// ---------------------------------------------------------------------------
module smf_vert #(
	parameter int unsigned DEPTH = 8192,
	parameter int unsigned AW    = 13
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_valid,
	input  smf_pkg::step_ctl_t ctl,
	input  logic [AW-1:0]      addr,
	input  logic [7:0]         hn,
	output logic               push,
	output smf_pkg::out_t      res,
	output logic               pend
);
	import smf_pkg::*;

	logic          valid_s1;
	step_ctl_t     ctl_s1;
	logic [AW-1:0] addr_s1;
	logic [7:0]    hn_s1;
	logic          byp_s1;
	logic [7:0]    bypm_s1, bypu_s1;

	logic [7:0] up_rd, mid_rd, mid, up_raw, up, third;
	logic [9:0] vsum;
	logic       hazard, wr_en;

	// Take forwarded rows where the previous step wrote the same column
	assign mid    = byp_s1 ? bypm_s1 : mid_rd;
	assign up_raw = byp_s1 ? bypu_s1 : up_rd;
	assign up     = ctl_s1.upmid ? mid : up_raw;
	assign third  = ctl_s1.drain ? mid : hn_s1;
	assign vsum   = {2'b00, up} + {2'b00, mid} + {2'b00, third};

	assign hazard = step_valid && valid_s1 && ctl_s1.wr && (addr_s1 == addr);
	assign wr_en  = valid_s1 && ctl_s1.wr;

	// Result towards the queue
	assign push           = valid_s1 && ctl_s1.emit;
	assign pend           = push;
	assign res.filtered   = mean3(vsum);
	assign res.frame_last = ctl_s1.last;

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= step_valid;
		end
	end

	// Stage payload and forwarded values
	always_ff @(posedge clk) begin
		ctl_s1  <= ctl;
		addr_s1 <= addr;
		hn_s1   <= hn;
		byp_s1  <= hazard;
		bypm_s1 <= hn_s1;
		bypu_s1 <= mid;
	end

	// Upper row takes the old middle row, middle row the new horizontal mean
	smf_row_ram #(.DEPTH(DEPTH), .AW(AW)) u_upper (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata (mid),
		.re    (step_valid),
		.raddr (addr),
		.rdata (up_rd)
	);

	smf_row_ram #(.DEPTH(DEPTH), .AW(AW)) u_middle (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata (hn_s1),
		.re    (step_valid),
		.raddr (addr),
		.rdata (mid_rd)
	);

endmodule
